// ===== rtl/sli_pkg.sv =====
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants for the sorted list core
// Entry type, capacity, status and opcode codes, and the command that the
// top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 7;

    typedef logic signed [DATA_W-1:0] t_entry;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_opcode;

    // Broadcast to all cells in the cycle a request is accepted
    typedef struct packed {
        logic   ins_en;
        logic   del_en;
        t_entry value;
    } t_cell_cmd;

endpackage

// ===== rtl/sli_cell.sv =====
// ----------------------------------------------------------------------------
// sli_cell: one slot of the sorted list
// Holds one entry, compares it against the broadcast value and takes its
// own value, the new value or a neighbor's entry on insert or delete.
// ----------------------------------------------------------------------------
module sli_cell
    import sli_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  logic      i_occupied,
    input  logic      i_left_lt,
    input  t_entry    i_left_entry,
    input  t_entry    i_right_entry,
    output t_entry    o_entry,
    output logic      o_lt,
    output logic      o_hit
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_at_pos;

    always_comb begin
        o_lt     = i_occupied && (r_entry < i_cmd.value);
        // first slot that is not smaller than the value
        w_at_pos = !o_lt && i_left_lt;
        o_hit    = w_at_pos && i_occupied && (r_entry == i_cmd.value);

        n_entry = r_entry;
        if (i_cmd.ins_en && !o_lt) begin
            n_entry = w_at_pos ? i_cmd.value : i_left_entry;
        end else if (i_cmd.del_en && !o_lt) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/sorted_list_insert_delete_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_core: bounded ascending list of signed values
// Insert places a value ahead of the first stored value not smaller than
// it; delete removes the first equal value. Each request yields a status
// and the new count.
// ----------------------------------------------------------------------------
//
//  channel | handshake                   | payload
//  --------+-----------------------------+--------------------------
//  in      | i_in_valid / o_in_ready     | i_opcode, i_value
//  out     | o_out_valid / i_out_ready   | o_status, o_count
//
//  Every request completes in the cycle it is accepted: all cells compare
//  in parallel and shift by one slot at the same clock edge, so the block
//  takes one request per cycle unless the output stalls. The result goes
//  to the output register at that edge. Input ready is high whenever that
//  register is empty or being drained, so a stalled output only stops the
//  input once one result waits. Reset clears the count and the output valid;
//  the cell contents are not reset, only slots below the count are ever
//  compared.
module sorted_list_insert_delete_core
    import sli_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic signed [31:0]   i_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [COUNT_W-1:0]   o_count
);

    // Stored count and output register
    t_cnt               r_count;
    t_cnt               n_count;
    logic               r_out_valid;
    t_status            r_out_status;
    t_status            n_status;
    logic [COUNT_W-1:0] r_out_count;

    logic      w_accept;
    logic      w_is_del;
    logic      w_full;
    logic      w_found;
    t_cell_cmd w_cmd;

    // Chain wiring between neighbor cells
    t_entry                w_entry [CAPACITY];
    logic   [CAPACITY-1:0] w_lt;
    logic   [CAPACITY-1:0] w_hit;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_del   = (i_opcode == OP_DELETE);
    assign w_full     = (r_count == t_cnt'(CAPACITY));
    assign w_found    = |w_hit;

    // Broadcast the command; shift only when the request changes the list
    always_comb begin
        w_cmd.value  = i_value;
        w_cmd.ins_en = w_accept && !w_is_del && !w_full;
        w_cmd.del_en = w_accept && w_is_del && w_found;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic   w_left_lt;
            t_entry w_left_entry;
            t_entry w_right_entry;

            if (g == 0) begin : g_head
                // the head slot is always a candidate insert position
                assign w_left_lt    = 1'b1;
                assign w_left_entry = i_value;
            end else begin : g_body
                assign w_left_lt    = w_lt[g-1];
                assign w_left_entry = w_entry[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right_entry = w_entry[g];
            end else begin : g_mid
                assign w_right_entry = w_entry[g+1];
            end

            sli_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_occupied    (r_count > t_cnt'(g)),
                .i_left_lt     (w_left_lt),
                .i_left_entry  (w_left_entry),
                .i_right_entry (w_right_entry),
                .o_entry       (w_entry[g]),
                .o_lt          (w_lt[g]),
                .o_hit         (w_hit[g])
            );
        end
    endgenerate

    // Status and next count for the request on the input
    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        if (!w_is_del) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + t_cnt'(1);
            end
        end else begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else if (!w_found) begin
                n_status = ST_NOT_FOUND;
            end else begin
                n_count = r_count - t_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the result: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_status <= n_status;
            r_out_count  <= COUNT_W'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(CAPACITY))
        else $error("stored count exceeds capacity");

    a_insert_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_del && !w_full) |=> (r_count == $past(r_count) + t_cnt'(1)))
        else $error("insert did not grow the count by one");

    a_delete_shrinks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_del && w_found) |=> (r_count == $past(r_count) - t_cnt'(1)))
        else $error("delete did not shrink the count by one");

    a_single_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell claims the first match");

    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FULL) |->
            (r_out_count == COUNT_W'(CAPACITY)))
        else $error("full status with a count below capacity");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_list_insert_delete_core
// Keeps an ascending shadow list, predicts the status and count of every
// request, and checks each result in order. A directed table comes first,
// then fill and drain phases of random requests, with random idling until the last items.
// ----------------------------------------------------------------------------
module testbench;
    import sli_pkg::*;

    // One directed row: a request repeated reps times, with a typed-in
    // expectation where it is obvious
    typedef struct packed {
        t_opcode            op;
        logic [DATA_W-1:0]  value;
        int                 reps;
        logic               typed;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_stim_row;

    typedef struct {
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_list_outcome;

    localparam int N_ROWS = 26;
    localparam t_stim_row DIRECTED_ROWS [N_ROWS] = '{
        '{OP_DELETE, 32'h0000_0000,  1, 1'b1, ST_EMPTY,     7'd0},
        '{OP_INSERT, 32'h7FFF_FFFF,  1, 1'b1, ST_DONE,      7'd1},
        '{OP_INSERT, 32'h8000_0000,  1, 1'b1, ST_DONE,      7'd2},
        '{OP_INSERT, 32'h0000_0000,  1, 1'b0, ST_DONE,      7'd0},
        '{OP_INSERT, 32'hFFFF_FFFF,  1, 1'b0, ST_DONE,      7'd0},
        '{OP_INSERT, 32'h0000_0000,  1, 1'b0, ST_DONE,      7'd0},
        '{OP_INSERT, 32'h5555_5555,  1, 1'b0, ST_DONE,      7'd0},
        '{OP_INSERT, 32'hAAAA_AAAA,  1, 1'b0, ST_DONE,      7'd0},
        '{OP_DELETE, 32'h0000_0005,  1, 1'b1, ST_NOT_FOUND, 7'd7},
        '{OP_DELETE, 32'h0000_0000,  1, 1'b0, ST_DONE,      7'd0},
        '{OP_DELETE, 32'h8000_0000,  1, 1'b0, ST_DONE,      7'd0},
        '{OP_DELETE, 32'h7FFF_FFFF,  1, 1'b0, ST_DONE,      7'd0},
        '{OP_DELETE, 32'h0000_0000,  1, 1'b0, ST_DONE,      7'd0},
        '{OP_DELETE, 32'hFFFF_FFFF,  1, 1'b0, ST_DONE,      7'd0},
        '{OP_DELETE, 32'h5555_5555,  1, 1'b0, ST_DONE,      7'd0},
        '{OP_DELETE, 32'hAAAA_AAAA,  1, 1'b1, ST_DONE,      7'd0},
        '{OP_DELETE, 32'hAAAA_AAAA,  1, 1'b1, ST_EMPTY,     7'd0},
        // fill to capacity with one repeated value
        '{OP_INSERT, 32'h0000_002A, 64, 1'b0, ST_DONE,      7'd0},
        '{OP_INSERT, 32'h0000_0001,  1, 1'b1, ST_FULL,      7'd64},
        '{OP_DELETE, 32'h0000_0003,  1, 1'b1, ST_NOT_FOUND, 7'd64},
        '{OP_DELETE, 32'h0000_002A,  1, 1'b1, ST_DONE,      7'd63},
        '{OP_INSERT, 32'hFFFF_FFFB,  1, 1'b1, ST_DONE,      7'd64},
        '{OP_INSERT, 32'h8000_0000,  1, 1'b1, ST_FULL,      7'd64},
        '{OP_DELETE, 32'hFFFF_FFFB,  1, 1'b1, ST_DONE,      7'd63},
        // drain back to empty
        '{OP_DELETE, 32'h0000_002A, 63, 1'b0, ST_DONE,      7'd0},
        '{OP_DELETE, 32'h0000_002A,  1, 1'b1, ST_EMPTY,     7'd0}
    };

    localparam int N_PHASES       = 4;
    localparam int PHASE_ITEMS    = 100;
    localparam int QUIET_FROM     = 320;   // random items after this run without idling
    localparam int DRAIN_LIMIT    = 5000;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic               i_opcode    = OP_INSERT;
    logic signed [31:0] i_value     = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    logic [1:0]         o_status;
    logic [COUNT_W-1:0] o_count;

    // shadow of the sorted list
    t_entry        shadow_list [CAPACITY];
    int            shadow_len;
    t_list_outcome pending_outcomes [$];

    bit idle_on  = 1'b1;
    int gap_pct  = 20;
    int error_count;
    int results_checked;
    int insert_count, delete_count, full_drops, empty_deletes, missed_deletes;

    sorted_list_insert_delete_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

    // Apply one request to the shadow list and return its status and count.
    // Insert goes ahead of the first entry that is not smaller; delete takes
    // the first equal entry.
    function automatic void apply_list_op(input t_opcode op, input t_entry val,
                                          output t_list_outcome outcome);
        int pos;
        pos = 0;
        if (op == OP_INSERT) begin
            insert_count++;
            if (shadow_len >= CAPACITY) begin
                outcome.status = ST_FULL;
                full_drops++;
            end else begin
                while (pos < shadow_len && shadow_list[pos] < val) pos++;
                for (int k = shadow_len; k > pos; k--) shadow_list[k] = shadow_list[k-1];
                shadow_list[pos] = val;
                shadow_len++;
                outcome.status = ST_DONE;
            end
        end else begin
            delete_count++;
            if (shadow_len == 0) begin
                outcome.status = ST_EMPTY;
                empty_deletes++;
            end else begin
                while (pos < shadow_len && shadow_list[pos] != val) pos++;
                if (pos >= shadow_len) begin
                    outcome.status = ST_NOT_FOUND;
                    missed_deletes++;
                end else begin
                    for (int k = pos; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k+1];
                    shadow_len--;
                    outcome.status = ST_DONE;
                end
            end
        end
        outcome.count = shadow_len[COUNT_W-1:0];
    endfunction

    // Present one request, hold it until accepted, then log its outcome.
    // A typed-in expectation replaces the predicted one for that request.
    task automatic send_request(input t_opcode op, input t_entry val, input logic typed,
                                input t_status exp_status, input logic [COUNT_W-1:0] exp_count);
        t_list_outcome outcome;
        if (idle_on && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        apply_list_op(op, val, outcome);
        if (typed) begin
            outcome.status = exp_status;
            outcome.count  = exp_count;
        end
        pending_outcomes.push_back(outcome);
    endtask

    // Clustered small values so duplicates pile up, plus extremes
    // and, most often, full-range values
    function automatic t_entry pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pick_value = $signed($urandom_range(0, 16)) - 8;
            4: begin
                case ($urandom_range(0, 3))
                    0:       pick_value = 32'sh8000_0000;
                    1:       pick_value = 32'sh7FFF_FFFF;
                    2:       pick_value = 32'sh0000_0000;
                    default: pick_value = -32'sd1;
                endcase
            end
            default: pick_value = $urandom;
        endcase
    endfunction

    // Output side: random stall bursts, else runs of ready
    initial begin
        forever begin
            if (idle_on && $urandom_range(0, 99) < 30) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    // Compare each drained result with the oldest expectation
    always @(posedge i_clk) begin : check_outcomes
        t_list_outcome want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result: status %0d, count %0d", o_status, o_count);
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                results_checked++;
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, o_status);
                    error_count++;
                end
                if (o_count !== want.count) begin
                    $error("count mismatch: expected %0d, actual %0d", want.count, o_count);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_stim_row row;
        t_opcode   op;
        t_entry    val;
        int        item;
        int        ins_pct;
        int        drain_cycles;

        shadow_len = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            for (int k = 0; k < row.reps; k++)
                send_request(row.op, row.value, row.typed, row.status, row.count);
        end

        // random: alternate fill-biased and drain-biased phases so the list
        // swings between full and empty several times
        item = 0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            ins_pct = (ph % 2 == 0) ? 85 : 15;
            case (ph)
                0:       gap_pct = 20;
                1:       gap_pct = 35;
                2:       gap_pct = 10;
                default: gap_pct = 25;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (item == QUIET_FROM) idle_on = 1'b0;
                if ($urandom_range(0, 99) < ins_pct) begin
                    op  = OP_INSERT;
                    val = pick_value();
                end else begin
                    op = OP_DELETE;
                    // mostly hit a stored value, sometimes miss
                    if (shadow_len > 0 && $urandom_range(0, 99) < 90)
                        val = shadow_list[$urandom_range(0, shadow_len - 1)];
                    else
                        val = pick_value();
                end
                send_request(op, val, 1'b0, ST_DONE, '0);
                item++;
            end
        end
        i_in_valid <= 1'b0;

        // drain outstanding results, then allow a few quiet cycles
        drain_cycles = 0;
        while (pending_outcomes.size() > 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_outcomes.size() > 0) begin
            $error("%0d expected results never arrived", pending_outcomes.size());
            error_count++;
        end

        $display("Checked %0d results from %0d inserts and %0d deletes.",
                 results_checked, insert_count, delete_count);
        $display("Dropped inserts on a full list: %0d, deletes on empty: %0d, misses: %0d.",
                 full_drops, empty_deletes, missed_deletes);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
